FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked property that must hold during reset as well.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: src/rnfa_pkg.sv
// Package for the ring neighbor fair arbiter: transaction types and codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package rnfa_pkg;

  localparam int ID_WIDTH        = 4;
  localparam int RING_SIZE_WIDTH = 5;

  localparam logic [RING_SIZE_WIDTH-1:0] RING_SIZE_RESET = 5'd5;

  // Input function codes
  localparam logic FUNC_REQUEST = 1'b0;

  // Per-requester state codes
  localparam logic [1:0] ST_THINKING = 2'd0;
  localparam logic [1:0] ST_HUNGRY   = 2'd1;
  localparam logic [1:0] ST_EATING   = 2'd2;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef struct packed {
    logic                func;
    logic [ID_WIDTH-1:0] requester_id;
  } rnfa_in_t;

  typedef struct packed {
    logic                grant_valid;
    logic [ID_WIDTH-1:0] granted_id;
    logic                status;
    logic                last;
  } rnfa_out_t;

  // Up to two results produced by one transaction
  typedef struct packed {
    logic      two;
    rnfa_out_t first;
    rnfa_out_t second;
  } rnfa_pair_t;

endpackage

`default_nettype wire

FILE: src/ring_neighbor_fair_arbiter.sv
// Top level of the ring neighbor fair arbiter: input register, ring size
// register, arbitration core and result buffer. Depends on rnfa_pkg.
//
// Usage: requests and releases arrive on in_data (func, requester_id) with
// in_valid/in_ready; results leave on out_data with out_valid/out_ready.
// A request gives one result; a release gives one or two (grants to the left,
// then the right neighbor), the final one marked by last.
// The first result goes through the input register, then the output register.
// One transaction per cycle while the receiver takes every result and each
// gives one result, set by the single output port draining the two-entry
// result buffer; a release granting both neighbors holds the next one back.
// The input register takes a new transaction while a result waits to be
// taken; when the receiver stalls, the buffer fills and in_ready drops.
// cfg_we/cfg_wdata write the ring size; write it only while idle.
// Reset (rst, synchronous): all requesters thinking, counts and maximum zero,
// ring size 5, both channels empty.
`default_nettype none

module ring_neighbor_fair_arbiter import rnfa_pkg::*; #(
  parameter int MAX_REQUESTERS = 16,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rnfa_in_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rnfa_out_t                  out_data,
  input  logic                       cfg_we,
  input  logic [RING_SIZE_WIDTH-1:0] cfg_wdata
);

  logic                       hold_valid;
  rnfa_in_t                   hold_item;
  logic [RING_SIZE_WIDTH-1:0] ring_size;
  logic                       can_push;
  logic                       fire;
  rnfa_pair_t                 pair;

  assign fire     = hold_valid && can_push;
  assign in_ready = !hold_valid || fire;

  // Ring size register
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= RING_SIZE_RESET;
    end else if (cfg_we) begin
      ring_size <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  rnfa_core #(
    .MAX_REQUESTERS (MAX_REQUESTERS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (hold_item),
    .ring_size (ring_size),
    .res       (pair)
  );

  rnfa_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .pair      (pair),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: src/rnfa_core.sv
// Arbitration core: per-requester state, grant counts, maximum count, and
// the single-pass grant decision. Depends on rnfa_pkg.
`default_nettype none

module rnfa_core import rnfa_pkg::*; #(
  parameter int MAX_REQUESTERS = 16,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  rnfa_in_t                   item,
  input  logic [RING_SIZE_WIDTH-1:0] ring_size,
  output rnfa_pair_t                 res
);

  localparam int IW  = $clog2(MAX_REQUESTERS);
  localparam int NW  = $clog2(MAX_REQUESTERS + 1);
  localparam int XW  = (NW > RING_SIZE_WIDTH) ? NW : RING_SIZE_WIDTH;
  localparam logic [XW-1:0] N_MAX = XW'(MAX_REQUESTERS);
  localparam logic [XW-1:0] N_MIN = XW'(2);
  localparam logic [COUNT_WIDTH-1:0] CNT_SAT = '1;

  function automatic logic [IW-1:0] left_of(input logic [IW-1:0] x,
                                            input logic [IW-1:0] last_ix);
    return (x == '0) ? last_ix : x - IW'(1);
  endfunction

  function automatic logic [IW-1:0] right_of(input logic [IW-1:0] x,
                                             input logic [IW-1:0] last_ix);
    return (x == last_ix) ? '0 : x + IW'(1);
  endfunction

  logic [1:0]             req_state       [MAX_REQUESTERS];
  logic [1:0]             req_state_next  [MAX_REQUESTERS];
  logic [COUNT_WIDTH-1:0] grant_count     [MAX_REQUESTERS];
  logic [COUNT_WIDTH-1:0] grant_count_next[MAX_REQUESTERS];
  logic [COUNT_WIDTH-1:0] inc_cnt         [MAX_REQUESTERS];
  logic [COUNT_WIDTH-1:0] max_count;
  logic [COUNT_WIDTH-1:0] max_count_next;
  logic [COUNT_WIDTH-1:0] max_mid;

  logic [MAX_REQUESTERS-1:0] eat_v, hung_v, lowm_v, lh_v;

  logic [XW-1:0] rs_x, n_eff;
  logic [IW-1:0] last_ix, ix, l, r, ll, rr, a_ix;
  logic          two_ring, id_ok, is_req, st_ok, take;
  logic          g_req, g_left, g_right, g_a, g_b;

  // Per-lane flags and saturating increments
  always_comb begin
    for (int i = 0; i < MAX_REQUESTERS; i++) begin
      eat_v[i]   = (req_state[i] == ST_EATING);
      hung_v[i]  = (req_state[i] == ST_HUNGRY);
      lowm_v[i]  = (grant_count[i] < max_count);
      inc_cnt[i] = (grant_count[i] == CNT_SAT) ? grant_count[i]
                                               : grant_count[i] + COUNT_WIDTH'(1);
    end
    lh_v = hung_v & lowm_v;
  end

  // Effective ring size and neighbor indexes
  always_comb begin
    rs_x     = XW'(ring_size);
    n_eff    = (rs_x < N_MIN) ? N_MIN : ((rs_x > N_MAX) ? N_MAX : rs_x);
    last_ix  = IW'(n_eff - XW'(1));
    two_ring = (n_eff == N_MIN);
    ix       = IW'(item.requester_id);
    id_ok    = (XW'(item.requester_id) < n_eff);
    l        = left_of(ix, last_ix);
    r        = right_of(ix, last_ix);
    ll       = left_of(l, last_ix);
    rr       = right_of(r, last_ix);
  end

  // Grant decision
  always_comb begin
    is_req = (item.func == FUNC_REQUEST);
    st_ok  = is_req ? (req_state[ix] == ST_THINKING) : (req_state[ix] == ST_EATING);
    take   = id_ok && st_ok;

    // Request: both neighbors free and neither a starved hungry one
    g_req = !eat_v[l] && !eat_v[r] && !lh_v[l] && !lh_v[r];

    // Release, left first; on a two-place ring the far side is the releaser
    g_left = hung_v[l] && (two_ring || (!eat_v[ll] && !lh_v[ll]));

    // Release, right next; sees the left grant and the raised maximum
    g_right = !two_ring && hung_v[r] && !((rr == l) && g_left) && !eat_v[rr] &&
              !(hung_v[rr] && (lowm_v[rr] || (g_left && grant_count[rr] < inc_cnt[l])));

    g_a  = take && (is_req ? g_req : g_left);
    g_b  = take && !is_req && g_right;
    a_ix = is_req ? ix : l;
  end

  // Result pair
  always_comb begin
    res.two    = g_a && g_b;
    res.second = '{grant_valid: 1'b1, granted_id: ID_WIDTH'(r),
                   status: STATUS_OK, last: 1'b1};
    if (!take) begin
      res.first = '{grant_valid: 1'b0, granted_id: '0,
                    status: STATUS_IGNORED, last: 1'b1};
    end else if (g_a) begin
      res.first = '{grant_valid: 1'b1, granted_id: ID_WIDTH'(a_ix),
                    status: STATUS_OK, last: !g_b};
    end else if (g_b) begin
      res.first = res.second;
    end else begin
      res.first = '{grant_valid: 1'b0, granted_id: '0,
                    status: STATUS_OK, last: 1'b1};
    end
  end

  // Next state per lane and new maximum
  always_comb begin
    for (int i = 0; i < MAX_REQUESTERS; i++) begin
      req_state_next[i]   = req_state[i];
      grant_count_next[i] = grant_count[i];
      if (take) begin
        if (IW'(i) == ix) begin
          req_state_next[i] = is_req ? (g_a ? ST_EATING : ST_HUNGRY) : ST_THINKING;
        end
        if ((g_a && IW'(i) == a_ix) || (g_b && IW'(i) == r)) begin
          req_state_next[i]   = ST_EATING;
          grant_count_next[i] = inc_cnt[i];
        end
      end
    end
    max_mid        = (g_a && inc_cnt[a_ix] > max_count) ? inc_cnt[a_ix] : max_count;
    max_count_next = (g_b && inc_cnt[r] > max_mid) ? inc_cnt[r] : max_mid;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_REQUESTERS; i++) begin
        req_state[i]   <= ST_THINKING;
        grant_count[i] <= '0;
      end
      max_count <= '0;
    end else if (fire) begin
      for (int i = 0; i < MAX_REQUESTERS; i++) begin
        req_state[i]   <= req_state_next[i];
        grant_count[i] <= grant_count_next[i];
      end
      max_count <= max_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/rnfa_out_buf.sv
// Two-entry result buffer: output register plus one pending slot for the
// second grant of a release. Depends on rnfa_pkg.
`default_nettype none

module rnfa_out_buf import rnfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rnfa_pair_t pair,
  output logic       can_push,
  output logic       out_valid,
  input  logic       out_ready,
  output rnfa_out_t  out_data
);

  logic      pend_valid;
  rnfa_out_t pend_data;
  logic      slot_free;
  logic      pend_move;

  assign slot_free = !out_valid || out_ready;
  assign can_push  = !pend_valid && slot_free;
  assign pend_move = pend_valid && slot_free;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (push) begin
      out_valid  <= 1'b1;
      pend_valid <= pair.two;
    end else if (pend_move) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_data  <= pair.first;
      pend_data <= pair.second;
    end else if (pend_move) begin
      out_data  <= pend_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/rnfa_checker.sv
// Port-level checker for the ring neighbor fair arbiter, with its bind.
// Depends on rnfa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rnfa_checker import rnfa_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input rnfa_out_t out_data
);

  logic out_take;
  logic out_closing;

  assign out_take    = out_valid && out_ready;
  assign out_closing = out_valid && out_data.grant_valid && out_data.last;

  // A stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // Reset empties the result channel
  `ASSERT_CLK_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

  // A non-final result is followed at once by the second grant
  `ASSERT_CLK(a_second_grant, clk, rst, out_take && !out_data.last |=> out_closing)

endmodule

bind ring_neighbor_fair_arbiter rnfa_checker u_rnfa_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: tb/ring_neighbor_fair_arbiter_test.sv
// Self-checking bench for ring_neighbor_fair_arbiter: directed and random
// traffic checked against a built-in predictor.
// Depends on rnfa_pkg and the ring_neighbor_fair_arbiter RTL.
`timescale 1ns / 1ps

module ring_neighbor_fair_arbiter_test;
  import rnfa_pkg::*;

  localparam int NREQ     = 16;
  localparam int CNT_W    = 16;
  localparam int LIMIT_NS = 3_000_000;
  localparam logic FUNC_RELEASE = ~FUNC_REQUEST;

  // Arbiter state as the predictor sees it
  typedef struct packed {
    logic [NREQ-1:0][1:0]       activity;
    logic [NREQ-1:0][CNT_W-1:0] grants;
    logic [CNT_W-1:0]           top_grants;
    logic [RING_SIZE_WIDTH-1:0] ring_size;
  } ring_state_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  rnfa_in_t                   in_data;
  logic                       out_valid;
  logic                       out_ready;
  rnfa_out_t                  out_data;
  logic                       cfg_we;
  logic [RING_SIZE_WIDTH-1:0] cfg_wdata;

  ring_state_t ring_model;   // advanced on each accepted transaction
  ring_state_t ring_plan;    // advanced as stimulus is queued
  rnfa_in_t    pending_ops[$];
  rnfa_out_t   due_results[$];
  rnfa_pair_t  predicted;
  rnfa_out_t   want;
  int          mismatches;
  int          send_gap_pct;
  int          recv_stall_pct;

  logic [RING_SIZE_WIDTH-1:0] ring_steps [12] =
    '{5'd16, 5'd3, 5'd1, 5'd7, 5'd31, 5'd2, 5'd12, 5'd0, 5'd17, 5'd5, 5'd9, 5'd16};

  ring_neighbor_fair_arbiter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic int ring_len(logic [RING_SIZE_WIDTH-1:0] v);
    if (v < 2) return 2;
    if (v > NREQ) return NREQ;
    return int'(v);
  endfunction

  function automatic int left_of(int id, int n);
    return (id == 0) ? n - 1 : id - 1;
  endfunction

  function automatic int right_of(int id, int n);
    return (id + 1 >= n) ? 0 : id + 1;
  endfunction

  // Both neighbors off the resource, and no starving hungry neighbor
  function automatic bit may_seat(ring_state_t s, int id, int n);
    int l;
    int r;
    l = left_of(id, n);
    r = right_of(id, n);
    if (s.activity[l] == ST_EATING || s.activity[r] == ST_EATING) return 1'b0;
    if (s.activity[l] == ST_HUNGRY && s.grants[l] < s.top_grants) return 1'b0;
    if (s.activity[r] == ST_HUNGRY && s.grants[r] < s.top_grants) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void seat(inout ring_state_t s, input int id);
    if (s.grants[id] != '1) s.grants[id] = s.grants[id] + 1'b1;
    if (s.grants[id] > s.top_grants) s.top_grants = s.grants[id];
    s.activity[id] = ST_EATING;
  endfunction

  function automatic rnfa_out_t result_of(logic gv, int gid, logic st, logic fin);
    rnfa_out_t r;
    r.grant_valid = gv;
    r.granted_id  = gid[ID_WIDTH-1:0];
    r.status      = st;
    r.last        = fin;
    return r;
  endfunction

  // One transaction in, one or two results out
  function automatic rnfa_pair_t arbitrate(inout ring_state_t s, input rnfa_in_t t);
    rnfa_pair_t p;
    int n;
    int id;
    int c;
    int k;
    p = '0;
    n = ring_len(s.ring_size);
    id = int'(t.requester_id);
    p.first = result_of(1'b0, 0, STATUS_IGNORED, 1'b1);
    if (id >= n) return p;
    if (t.func == FUNC_REQUEST) begin
      if (s.activity[id] != ST_THINKING) return p;
      s.activity[id] = ST_HUNGRY;
      if (may_seat(s, id, n)) begin
        seat(s, id);
        p.first = result_of(1'b1, id, STATUS_OK, 1'b1);
      end else begin
        p.first = result_of(1'b0, 0, STATUS_OK, 1'b1);
      end
      return p;
    end
    if (s.activity[id] != ST_EATING) return p;
    s.activity[id] = ST_THINKING;
    k = 0;
    // left neighbor first, then right; on a two-place ring they coincide
    for (int i = 0; i < 2; i++) begin
      c = (i == 0) ? left_of(id, n) : right_of(id, n);
      if (s.activity[c] == ST_HUNGRY && may_seat(s, c, n)) begin
        seat(s, c);
        if (k == 0) p.first = result_of(1'b1, c, STATUS_OK, 1'b0);
        else p.second = result_of(1'b1, c, STATUS_OK, 1'b1);
        k++;
      end
    end
    if (k == 0) p.first = result_of(1'b0, 0, STATUS_OK, 1'b1);
    else if (k == 1) p.first.last = 1'b1;
    else p.two = 1'b1;
    return p;
  endfunction

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  task automatic send(logic f, int id);
    rnfa_in_t t;
    t.func = f;
    t.requester_id = id[ID_WIDTH-1:0];
    void'(arbitrate(ring_plan, t));
    pending_ops.push_back(t);
  endtask

  // Wait until every queued transaction is accepted and every result is in
  task automatic settle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_ring(logic [RING_SIZE_WIDTH-1:0] v);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_model.ring_size = v;
    ring_plan.ring_size  = v;
    @(negedge clk);
  endtask

  // Mostly legal traffic that avoids leaving hungry requesters with nobody
  // eating (nothing could ever wake them); the rest is random noise.
  task automatic add_random_item();
    rnfa_in_t    t;
    ring_state_t trial;
    int          n;
    bit          hungry;
    bit          eating;
    n = ring_len(ring_plan.ring_size);
    t.func = 1'($urandom_range(1));
    t.requester_id = ID_WIDTH'($urandom_range(NREQ - 1));
    if ($urandom_range(99) >= 12) begin
      for (int tries = 0; tries < 8; tries++) begin
        t.requester_id = ID_WIDTH'($urandom_range(n - 1));
        t.func = (ring_plan.activity[t.requester_id] == ST_EATING) ?
                 FUNC_RELEASE : FUNC_REQUEST;
        if (ring_plan.activity[t.requester_id] == ST_HUNGRY) continue;
        trial = ring_plan;
        void'(arbitrate(trial, t));
        hungry = 1'b0;
        eating = 1'b0;
        for (int k = 0; k < n; k++) begin
          if (trial.activity[k] == ST_HUNGRY) hungry = 1'b1;
          if (trial.activity[k] == ST_EATING) eating = 1'b1;
        end
        if (!(hungry && !eating)) break;
      end
    end
    send(t.func, int'(t.requester_id));
  endtask

  // ---------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------
  // Driver: one transaction from the pending queue at a time
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = arbitrate(ring_model, in_data);
        due_results.push_back(predicted.first);
        if (predicted.two) due_results.push_back(predicted.second);
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: gv=%0d id=%0d st=%0d last=%0d",
                     out_data.grant_valid, out_data.granted_id,
                     out_data.status, out_data.last);
        end else begin
          want = due_results.pop_front();
          if (out_data.grant_valid !== want.grant_valid ||
              out_data.granted_id  !== want.granted_id  ||
              out_data.status      !== want.status      ||
              out_data.last        !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp gv/id/st/last=%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.grant_valid, want.granted_id, want.status, want.last,
                       out_data.grant_valid, out_data.granted_id,
                       out_data.status, out_data.last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = RING_SIZE_RESET;
    mismatches = 0;
    // reset state: all thinking, counts zero
    ring_model = '0;
    ring_model.ring_size = RING_SIZE_RESET;
    ring_plan  = ring_model;
    send_gap_pct   = 26;
    recv_stall_pct = 71;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, ring of five after reset
    send(FUNC_REQUEST, 0);    // granted at once
    send(FUNC_REQUEST, 1);    // left neighbor eating: waits
    send(FUNC_REQUEST, 1);    // not thinking: ignored
    send(FUNC_RELEASE, 2);    // not eating: ignored
    send(FUNC_REQUEST, 5);    // beyond the ring
    send(FUNC_RELEASE, 15);   // beyond the ring
    send(FUNC_REQUEST, 4);    // right neighbor eating: waits
    send(FUNC_RELEASE, 0);    // grants both neighbors, left first
    send(FUNC_RELEASE, 4);
    send(FUNC_RELEASE, 1);
    send(FUNC_REQUEST, 2);
    send(FUNC_REQUEST, 3);    // waits on eating neighbor
    send(FUNC_REQUEST, 4);    // held back by the lower-count hungry neighbor
    send(FUNC_RELEASE, 2);    // single grant to the right
    send(FUNC_RELEASE, 3);
    send(FUNC_RELEASE, 4);

    // Ring size below range clamps to a two-place ring
    set_ring(5'd0);
    send(FUNC_REQUEST, 0);
    send(FUNC_REQUEST, 1);
    send(FUNC_RELEASE, 0);    // shared neighbor granted only once
    send(FUNC_RELEASE, 1);
    send(FUNC_REQUEST, 2);
    send(FUNC_RELEASE, 9);

    // Ring size above range clamps to the full ring
    set_ring(5'd31);
    send(FUNC_REQUEST, 15);
    send(FUNC_RELEASE, 15);

    // Random traffic over several ring sizes and three idling patterns
    for (int seg = 0; seg < 12; seg++) begin
      set_ring(ring_steps[seg]);
      case (seg / 4)
        0: begin
          send_gap_pct   = 26;
          recv_stall_pct = 71;
        end
        1: begin
          send_gap_pct   = 71;
          recv_stall_pct = 26;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < 160; i++) add_random_item();
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/rnfa_pkg.sv
src/rnfa_core.sv
src/rnfa_out_buf.sv
src/ring_neighbor_fair_arbiter.sv
src/rnfa_checker.sv
tb/ring_neighbor_fair_arbiter_test.sv
